/* design/hies_pkg.sv */
// Package for the Heun predictor-corrector step block: widths, register
// indexes, microcode opcodes, the control ROM and the saturation helper.
// No dependencies.
`default_nettype none

package hies_pkg;

    localparam int DATA_W        = 32;
    localparam int STEP_W        = 17;
    localparam int TOL_W         = 16;
    localparam int TRIES_W       = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int PC_W          = 4;
    localparam int OPND_W        = DATA_W + 1;
    localparam int PROD_W        = 2 * OPND_W;
    localparam int EXT_W         = PROD_W + 1;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 112;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_TRIES_DEF = 64;

    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(6554);
    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(7);
    localparam logic [TRIES_W-1:0] TRIES_RESET = TRIES_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X   = 3'd0,
        CFG_START_Y   = 3'd1,
        CFG_STEP_SIZE = 3'd2,
        CFG_TOLERANCE = 3'd3,
        CFG_MAX_TRIES = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_SQ_Y0,
        OP_F0,
        OP_MUL_H_F0,
        OP_EST,
        OP_SQ_EST,
        OP_F1,
        OP_SUM,
        OP_MUL_H_SUM,
        OP_YNEXT,
        OP_CHECK,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_LOOP,
        BR_END
    } br_t;

    typedef struct packed {
        op_t             op;
        br_t             br;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } clamp_t;

    localparam logic [PC_W-1:0] LOOP_PC = PC_W'(4);

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{op: OP_SQ_Y0,     br: BR_NEXT, target: '0};
            4'd1:    w = '{op: OP_F0,        br: BR_NEXT, target: '0};
            4'd2:    w = '{op: OP_MUL_H_F0,  br: BR_NEXT, target: '0};
            4'd3:    w = '{op: OP_EST,       br: BR_NEXT, target: '0};
            4'd4:    w = '{op: OP_SQ_EST,    br: BR_NEXT, target: '0};
            4'd5:    w = '{op: OP_F1,        br: BR_NEXT, target: '0};
            4'd6:    w = '{op: OP_SUM,       br: BR_NEXT, target: '0};
            4'd7:    w = '{op: OP_MUL_H_SUM, br: BR_NEXT, target: '0};
            4'd8:    w = '{op: OP_YNEXT,     br: BR_NEXT, target: '0};
            4'd9:    w = '{op: OP_CHECK,     br: BR_LOOP, target: LOOP_PC};
            default: w = '{op: OP_DONE,      br: BR_END,  target: '0};
        endcase
        return w;
    endfunction

    function automatic logic signed [EXT_W-1:0] sx(input logic signed [DATA_W-1:0] v);
        return {{(EXT_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic clamp_t clamp32(input logic signed [EXT_W-1:0] v);
        localparam logic signed [EXT_W-1:0] MAX_W = EXT_W'(64'sd2147483647);
        localparam logic signed [EXT_W-1:0] MIN_W = -EXT_W'(64'sd2147483648);
        clamp_t r;
        if (v > MAX_W)
        begin
            r.sat   = 1'b1;
            r.value = DATA_W'(MAX_W);
        end
        else if (v < MIN_W)
        begin
            r.sat   = 1'b1;
            r.value = DATA_W'(MIN_W);
        end
        else
        begin
            r.sat   = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/heun_iterated_ode_step.sv */
// Top level of the Heun predictor-corrector step for dy/dx = x + y^2.
// Microcoded sequencer over one shared multiplier; uses hies_pkg.
//
// One input transfer advances the integration by one step of size h and
// yields one result transfer. Each item runs four steps for the predictor,
// six microcode steps per corrector try (square, slope, sum, step multiply,
// y update, tolerance check) and one step to post the result, with every
// multiply through a single 33x33 multiplier. The number of tries runs from
// 1 up to max_tries, taken as 1 when zero and capped at MAX_TRIES_LIMIT.
// The next input is taken once the result has been posted to the output
// register. restart in the input reloads x and y from start_x and start_y.
// Configuration writes are always accepted and must occur only while idle.
`default_nettype none

module heun_iterated_ode_step
    import hies_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_TRIES_LIMIT = MAX_TRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // restart[0], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // x_value[31:0], y_value[63:32], end_slope[95:64], tries[102:96],
    // converged[103], saturated[104], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam logic signed [EXT_W-1:0] HALF_F  = EXT_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [EXT_W-1:0] HALF_F1 = EXT_W'(1) << FRAC_BITS;

    // configuration
    logic signed [DATA_W-1:0]  start_x_reg, start_y_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [TOL_W-1:0]          tol_reg;
    logic [TRIES_W-1:0]        max_tries_reg;

    // control
    logic                      busy_reg, busy_next;
    logic [PC_W-1:0]           pc_reg, pc_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0]  cur_x_reg, cur_x_next;
    logic signed [DATA_W-1:0]  cur_y_reg, cur_y_next;

    // datapath
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [DATA_W-1:0]  f0_reg, f0_next;
    logic signed [DATA_W-1:0]  f1_reg, f1_next;
    logic signed [DATA_W-1:0]  x1_reg, x1_next;
    logic signed [DATA_W-1:0]  est_reg, est_next;
    logic signed [DATA_W-1:0]  prev_reg, prev_next;
    logic signed [DATA_W-1:0]  ynext_reg, ynext_next;
    logic signed [OPND_W-1:0]  sum_reg, sum_next;
    logic [TRIES_W-1:0]        n_reg, n_next;
    logic                      conv_reg, conv_next;
    logic                      sat_reg, sat_next;

    // output payload
    logic [M_TDATA_W-1:0]      out_reg, out_next;

    ucode_t                    uw;
    logic                      in_xfer;
    logic                      out_free;
    logic signed [OPND_W-1:0]  mul_a, mul_b;
    logic signed [EXT_W-1:0]   prod_x, rnd_f, rnd_f1;
    logic signed [DATA_W-1:0]  x_sel;
    clamp_t                    sq_c, slope_c, est_c, x1_c, ynext_c;
    logic signed [OPND_W-1:0]  diff;
    logic [DATA_W-1:0]         abs_diff;
    logic                      conv_now;
    logic [TRIES_W-1:0]        limit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;
    assign uw        = ucode_rom(pc_reg);

    always_comb
    begin
        if (max_tries_reg == '0)
            limit = TRIES_W'(1);
        else if (max_tries_reg > TRIES_W'(MAX_TRIES_LIMIT))
            limit = TRIES_W'(MAX_TRIES_LIMIT);
        else
            limit = max_tries_reg;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (uw.op)
            OP_SQ_Y0:
            begin
                mul_a = OPND_W'(cur_y_reg);
                mul_b = OPND_W'(cur_y_reg);
            end
            OP_SQ_EST:
            begin
                mul_a = OPND_W'(est_reg);
                mul_b = OPND_W'(est_reg);
            end
            OP_MUL_H_F0:
            begin
                mul_a = OPND_W'(f0_reg);
                mul_b = OPND_W'(signed'({1'b0, step_reg}));
            end
            OP_MUL_H_SUM:
            begin
                mul_a = sum_reg;
                mul_b = OPND_W'(signed'({1'b0, step_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_x    = {prod_reg[PROD_W-1], prod_reg};
    assign rnd_f     = (prod_x + HALF_F) >>> FRAC_BITS;
    assign rnd_f1    = (prod_x + HALF_F1) >>> (FRAC_BITS + 1);
    assign x_sel     = (uw.op == OP_F0) ? cur_x_reg : x1_reg;

    assign sq_c    = clamp32(rnd_f);
    assign slope_c = clamp32(sx(x_sel) + sx(sq_c.value));
    assign est_c   = clamp32(sx(cur_y_reg) + rnd_f);
    assign x1_c    = clamp32(sx(cur_x_reg) + EXT_W'(step_reg));
    assign ynext_c = clamp32(sx(cur_y_reg) + rnd_f1);

    assign diff     = OPND_W'(ynext_reg) - OPND_W'(prev_reg);
    assign abs_diff = diff[OPND_W-1] ? DATA_W'(-diff) : DATA_W'(diff);
    assign conv_now = abs_diff <= DATA_W'(tol_reg);

    // sequencer
    always_comb
    begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        if (!busy_reg)
        begin
            if (in_xfer)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
                if (s_tdata[0])
                begin
                    cur_x_next = start_x_reg;
                    cur_y_next = start_y_reg;
                end
            end
        end
        else
        begin
            case (uw.br)
                BR_NEXT:
                    pc_next = pc_reg + PC_W'(1);
                BR_LOOP:
                    if (conv_now || n_reg >= limit)
                        pc_next = pc_reg + PC_W'(1);
                    else
                        pc_next = uw.target;
                BR_END:
                    if (out_free)
                    begin
                        busy_next    = 1'b0;
                        m_valid_next = 1'b1;
                        cur_x_next   = x1_reg;
                        cur_y_next   = ynext_reg;
                    end
                default:
                    pc_next = pc_reg;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        f0_next    = f0_reg;
        f1_next    = f1_reg;
        x1_next    = x1_reg;
        est_next   = est_reg;
        prev_next  = prev_reg;
        ynext_next = ynext_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        conv_next  = conv_reg;
        sat_next   = sat_reg;
        out_next   = out_reg;
        if (!busy_reg)
        begin
            sat_next  = 1'b0;
            conv_next = 1'b0;
        end
        else
        begin
            case (uw.op)
                OP_F0:
                begin
                    f0_next  = slope_c.value;
                    sat_next = sat_reg | sq_c.sat | slope_c.sat;
                end
                OP_EST:
                begin
                    est_next  = est_c.value;
                    prev_next = est_c.value;
                    x1_next   = x1_c.value;
                    n_next    = '0;
                    sat_next  = sat_reg | est_c.sat | x1_c.sat;
                end
                OP_SQ_EST:
                    n_next = n_reg + TRIES_W'(1);
                OP_F1:
                begin
                    f1_next  = slope_c.value;
                    sat_next = sat_reg | sq_c.sat | slope_c.sat;
                end
                OP_SUM:
                    sum_next = OPND_W'(f0_reg) + OPND_W'(f1_reg);
                OP_YNEXT:
                begin
                    ynext_next = ynext_c.value;
                    sat_next   = sat_reg | ynext_c.sat;
                end
                OP_CHECK:
                begin
                    prev_next = ynext_reg;
                    est_next  = ynext_reg;
                    conv_next = conv_now;
                end
                OP_DONE:
                    // hold a waiting result until it has been taken
                    if (out_free)
                        out_next = {7'b0, sat_reg, conv_reg, n_reg,
                                    f1_reg, ynext_reg, x1_reg};
                default:
                    sat_next = sat_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            step_reg      <= STEP_RESET;
            tol_reg       <= TOL_RESET;
            max_tries_reg <= TRIES_RESET;
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            m_valid_reg   <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_X:   start_x_reg   <= cfg_data;
                    CFG_START_Y:   start_y_reg   <= cfg_data;
                    CFG_STEP_SIZE: step_reg      <= cfg_data[STEP_W-1:0];
                    CFG_TOLERANCE: tol_reg       <= cfg_data[TOL_W-1:0];
                    CFG_MAX_TRIES: max_tries_reg <= cfg_data[TRIES_W-1:0];
                    default:       step_reg      <= step_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        f0_reg    <= f0_next;
        f1_reg    <= f1_next;
        x1_reg    <= x1_next;
        est_reg   <= est_next;
        prev_reg  <= prev_next;
        ynext_reg <= ynext_next;
        sum_reg   <= sum_next;
        n_reg     <= n_next;
        conv_reg  <= conv_next;
        sat_reg   <= sat_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire
